// ===== hdl/quaternion_to_dcm_defines.svh =====
// ----------------------------------------------------------------------------
// quaternion_to_dcm_defines.svh
// Assertion macros shared by the quaternion to DCM block.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_TO_DCM_DEFINES_SVH
`define QUATERNION_TO_DCM_DEFINES_SVH

`ifndef SYNTH
// Check a property outside reset.
`define QDCM_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// Check a property also through reset.
`define QDCM_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define QDCM_ASSERT(label, prop)
`define QDCM_ASSERT_RST(label, prop)
`endif

`endif

// ===== hdl/qdcm_pkg.sv =====
// ----------------------------------------------------------------------------
// qdcm_pkg
// Shared constants of the quaternion to DCM block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qdcm_pkg;
  localparam int COMPONENT_WIDTH_DEF = 16;
  localparam int NUM_ENTRIES = 9;
  // Matrix entry slots, row major.
  localparam int M11 = 0;
  localparam int M12 = 1;
  localparam int M13 = 2;
  localparam int M21 = 3;
  localparam int M22 = 4;
  localparam int M23 = 5;
  localparam int M31 = 6;
  localparam int M32 = 7;
  localparam int M33 = 8;
endpackage

// ===== hdl/qdcm_ifs.sv =====
// ----------------------------------------------------------------------------
// qdcm_ifs
// Valid/ready channels: quaternion in, matrix out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface qdcm_quat_if #(parameter int W = qdcm_pkg::COMPONENT_WIDTH_DEF);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] quat_w;
  logic signed [W-1:0] quat_x;
  logic signed [W-1:0] quat_y;
  logic signed [W-1:0] quat_z;
  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface qdcm_dcm_if #(parameter int W = qdcm_pkg::COMPONENT_WIDTH_DEF);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] m11, m12, m13, m21, m22, m23, m31, m32, m33;
  logic                zero_norm;
  modport source (output valid, m11, m12, m13, m21, m22, m23, m31, m32, m33,
                  zero_norm, input ready);
  modport sink (input valid, m11, m12, m13, m21, m22, m23, m31, m32, m33,
                zero_norm, output ready);
endinterface

// ===== hdl/qdcm_divider.sv =====
// ----------------------------------------------------------------------------
// qdcm_divider
// Nine-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qdcm_divider #(
  parameter int COMPONENT_WIDTH = qdcm_pkg::COMPONENT_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [2*COMPONENT_WIDTH+1:0]  num [qdcm_pkg::NUM_ENTRIES],
  input  logic        [2*COMPONENT_WIDTH+1:0]  den,
  output logic signed [COMPONENT_WIDTH-1:0]    res [qdcm_pkg::NUM_ENTRIES]
);
  import qdcm_pkg::*;

  localparam int W  = COMPONENT_WIDTH;
  localparam int F  = W - 2;
  localparam int NW = 2 * W + 2;
  localparam int NS = F + 2;

  logic [NW-1:0] den_s   [NS];
  logic [NW-1:0] rem     [NS][NUM_ENTRIES];
  logic [F:0]    quo     [NS][NUM_ENTRIES];
  logic          neg     [NS][NUM_ENTRIES];
  logic          sat     [NS][NUM_ENTRIES];
  logic [NW-1:0] mag_in  [NUM_ENTRIES];
  logic [NW:0]   sh      [NS-1][NUM_ENTRIES];
  logic          ge      [NS-1][NUM_ENTRIES];
  logic [F+1:0]  rnd     [NUM_ENTRIES];
  logic [W-1:0]  mag_out [NUM_ENTRIES];

  // Magnitudes at the entry and the trial subtraction of every stage.
  always_comb begin
    for (int l = 0; l < NUM_ENTRIES; l++) begin
      mag_in[l] = num[l][NW-1] ? NW'(-num[l]) : NW'(num[l]);
    end
    for (int k = 0; k < NS - 1; k++) begin
      for (int l = 0; l < NUM_ENTRIES; l++) begin
        sh[k][l] = {rem[k][l], 1'b0};
        ge[k][l] = (sh[k][l] >= {1'b0, den_s[k]});
      end
    end
  end

  // Entry stage flags ratios at or above one; then one quotient bit per stage.
  always_ff @(posedge clk) begin
    if (en) begin
      den_s[0] <= den;
      for (int l = 0; l < NUM_ENTRIES; l++) begin
        neg[0][l] <= num[l][NW-1];
        sat[0][l] <= (mag_in[l] >= den);
        rem[0][l] <= (mag_in[l] >= den) ? '0 : mag_in[l];
        quo[0][l] <= '0;
      end
      for (int k = 0; k < NS - 1; k++) begin
        den_s[k+1] <= den_s[k];
        for (int l = 0; l < NUM_ENTRIES; l++) begin
          rem[k+1][l] <= ge[k][l] ? NW'(sh[k][l] - {1'b0, den_s[k]}) : NW'(sh[k][l]);
          quo[k+1][l] <= {quo[k][l][F-1:0], ge[k][l]};
          neg[k+1][l] <= neg[k][l];
          sat[k+1][l] <= sat[k][l];
        end
      end
    end
  end

  // Round half away from zero, clamp to one, restore sign.
  always_comb begin
    for (int l = 0; l < NUM_ENTRIES; l++) begin
      rnd[l] = ((F+2)'(quo[NS-1][l]) + (F+2)'(1)) >> 1;
      mag_out[l] = (sat[NS-1][l] || rnd[l] > (F+2)'(1 << F)) ? W'(1 << F) : W'(rnd[l]);
      res[l] = neg[NS-1][l] ? $signed(-mag_out[l]) : $signed(mag_out[l]);
    end
  end
endmodule

// ===== hdl/quaternion_to_dcm.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_dcm
// Normalized quaternion to direction cosine matrix, signed Q1.(W-2).
// ----------------------------------------------------------------------------
//  channel  dir  payload                               handshake
//  quat     in   quat_w, quat_x, quat_y, quat_z        valid/ready
//  dcm      out  m11..m33, zero_norm                   valid/ready
//
// One quaternion enters per cycle while the pipeline is not held; the stages are
// one multiply stage, one sum stage, one magnitude stage, COMPONENT_WIDTH-1
// divider stages (one quotient bit each), and the output register.
// The whole pipeline advances on one enable; it holds when the output word
// waits and is not taken, so nothing is dropped or repeated.
// Reset (rst, synchronous) clears the valid bits only.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "quaternion_to_dcm_defines.svh"

module quaternion_to_dcm #(
  parameter int COMPONENT_WIDTH = qdcm_pkg::COMPONENT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  qdcm_quat_if.sink   quat,
  qdcm_dcm_if.source  dcm
);
  import qdcm_pkg::*;

  localparam int W     = COMPONENT_WIDTH;
  localparam int F     = W - 2;
  localparam int PW    = 2 * W;
  localparam int NW    = 2 * W + 2;
  localparam int DEPTH = F + 4;
  localparam logic signed [W-1:0] M_ONE = W'(1 << F);

  function automatic logic signed [NW-1:0] sx(input logic signed [PW-1:0] v);
    return NW'(v);
  endfunction

  function automatic logic signed [PW-1:0] sw(input logic signed [W-1:0] v);
    return PW'(v);
  endfunction

  logic                 en;
  logic [DEPTH-1:0]     vld;
  logic [DEPTH-1:0]     zr;
  logic signed [PW-1:0] ww, xx, yy, zz, xy, wz, xz, wy, yz, wx;
  logic signed [NW-1:0] num [NUM_ENTRIES];
  logic [NW-1:0]        den;
  logic signed [W-1:0]  res [NUM_ENTRIES];

  // Advance whenever the output register is free or being drained.
  assign en = !dcm.valid || dcm.ready;
  assign quat.ready = en;

  // Valid and zero-norm flags travel beside the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], quat.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zr[0] <= (quat.quat_w == '0) && (quat.quat_x == '0) &&
               (quat.quat_y == '0) && (quat.quat_z == '0);
      zr[DEPTH-1:1] <= zr[DEPTH-2:0];
    end
  end

  // Stage 1: all ten products, operands sign-extended to full width.
  always_ff @(posedge clk) begin
    if (en) begin
      ww <= sw(quat.quat_w) * sw(quat.quat_w);
      xx <= sw(quat.quat_x) * sw(quat.quat_x);
      yy <= sw(quat.quat_y) * sw(quat.quat_y);
      zz <= sw(quat.quat_z) * sw(quat.quat_z);
      xy <= sw(quat.quat_x) * sw(quat.quat_y);
      wz <= sw(quat.quat_w) * sw(quat.quat_z);
      xz <= sw(quat.quat_x) * sw(quat.quat_z);
      wy <= sw(quat.quat_w) * sw(quat.quat_y);
      yz <= sw(quat.quat_y) * sw(quat.quat_z);
      wx <= sw(quat.quat_w) * sw(quat.quat_x);
    end
  end

  // Stage 2: squared norm and the nine numerators, all exact.
  always_ff @(posedge clk) begin
    if (en) begin
      den      <= NW'(sx(ww) + sx(xx) + sx(yy) + sx(zz));
      num[M11] <= sx(ww) + sx(xx) - sx(yy) - sx(zz);
      num[M12] <= (sx(xy) + sx(wz)) <<< 1;
      num[M13] <= (sx(xz) - sx(wy)) <<< 1;
      num[M21] <= (sx(xy) - sx(wz)) <<< 1;
      num[M22] <= sx(ww) - sx(xx) + sx(yy) - sx(zz);
      num[M23] <= (sx(yz) + sx(wx)) <<< 1;
      num[M31] <= (sx(xz) + sx(wy)) <<< 1;
      num[M32] <= (sx(yz) - sx(wx)) <<< 1;
      num[M33] <= sx(ww) - sx(xx) - sx(yy) + sx(zz);
    end
  end

  // Stages 3 onward: magnitude, bit-serial division, rounding.
  qdcm_divider #(.COMPONENT_WIDTH(COMPONENT_WIDTH)) u_div (
    .clk (clk),
    .en  (en),
    .num (num),
    .den (den),
    .res (res)
  );

  // Output register; a zero quaternion forces zeros.
  always_ff @(posedge clk) begin
    if (rst) begin
      dcm.valid <= 1'b0;
    end else if (en) begin
      dcm.valid <= vld[DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dcm.zero_norm <= zr[DEPTH-1];
      dcm.m11 <= zr[DEPTH-1] ? '0 : res[M11];
      dcm.m12 <= zr[DEPTH-1] ? '0 : res[M12];
      dcm.m13 <= zr[DEPTH-1] ? '0 : res[M13];
      dcm.m21 <= zr[DEPTH-1] ? '0 : res[M21];
      dcm.m22 <= zr[DEPTH-1] ? '0 : res[M22];
      dcm.m23 <= zr[DEPTH-1] ? '0 : res[M23];
      dcm.m31 <= zr[DEPTH-1] ? '0 : res[M31];
      dcm.m32 <= zr[DEPTH-1] ? '0 : res[M32];
      dcm.m33 <= zr[DEPTH-1] ? '0 : res[M33];
    end
  end

  `QDCM_ASSERT(a_zero_gives_zeros, dcm.valid && dcm.zero_norm |-> dcm.m11 == '0 && dcm.m33 == '0)
  `QDCM_ASSERT(a_diag_in_range, dcm.valid |-> dcm.m11 <= M_ONE && dcm.m11 >= -M_ONE)
  `QDCM_ASSERT(a_stall_only_when_blocked, !quat.ready |-> dcm.valid && !dcm.ready)
  `QDCM_ASSERT_RST(a_empty_after_reset, rst |=> !dcm.valid)
endmodule

// ===== tb/sv/quaternion_to_dcm_tb.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_dcm_tb
// Self-checking bench: random and corner quaternions in, normalized matrices
// out, each word compared entry by entry against an exact local computation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quaternion_to_dcm_tb;
  localparam int W = qdcm_pkg::COMPONENT_WIDTH_DEF;
  localparam int F = W - 2;
  localparam int N_RANDOM = 1500;
  localparam int LATENCY = W + 3;
  localparam longint CYCLE_LIMIT = 400000;

  typedef logic signed [W-1:0] comp_t;
  typedef struct packed {
    comp_t w, x, y, z;
  } quat_t;
  typedef struct {
    comp_t m[qdcm_pkg::NUM_ENTRIES];
    logic  zero_norm;
  } dcm_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  qdcm_quat_if #(.W(W)) quat ();
  qdcm_dcm_if  #(.W(W)) dcm ();

  quaternion_to_dcm #(.COMPONENT_WIDTH(W)) uut (
    .clk  (clk),
    .rst  (rst),
    .quat (quat.sink),
    .dcm  (dcm.source)
  );

  always #5 clk = ~clk;

  quat_t  pending_quats[$];
  dcm_t   expected_dcms[$];
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  bit     hold_sender = 1'b0;
  int     error_count = 0;
  int     words_checked = 0;
  int     zero_words = 0;
  longint cycle_count = 0;

  // Round |num| * 2^F / den to nearest, ties away from zero, clamp to one.
  function automatic comp_t scaled_ratio(longint num, longint den);
    longint mag;
    longint q;
    bit     neg;
    neg = num < 0;
    mag = neg ? -num : num;
    if (mag >= den) begin
      q = longint'(1) << F;
    end else begin
      q = ((mag << (F + 1)) / den + 1) >>> 1;
      if (q > (longint'(1) << F)) q = longint'(1) << F;
    end
    return comp_t'(neg ? -q : q);
  endfunction

  function automatic dcm_t rotation_of(quat_t q);
    dcm_t   r;
    longint w, x, y, z, den;
    longint num[qdcm_pkg::NUM_ENTRIES];
    w = q.w; x = q.x; y = q.y; z = q.z;
    den = w*w + x*x + y*y + z*z;
    if (den == 0) begin
      foreach (r.m[i]) r.m[i] = '0;
      r.zero_norm = 1'b1;
      return r;
    end
    num[qdcm_pkg::M11] = w*w + x*x - y*y - z*z;
    num[qdcm_pkg::M12] = 2 * (x*y + w*z);
    num[qdcm_pkg::M13] = 2 * (x*z - w*y);
    num[qdcm_pkg::M21] = 2 * (x*y - w*z);
    num[qdcm_pkg::M22] = w*w - x*x + y*y - z*z;
    num[qdcm_pkg::M23] = 2 * (y*z + w*x);
    num[qdcm_pkg::M31] = 2 * (x*z + w*y);
    num[qdcm_pkg::M32] = 2 * (y*z - w*x);
    num[qdcm_pkg::M33] = w*w - x*x - y*y + z*z;
    foreach (r.m[i]) r.m[i] = scaled_ratio(num[i], den);
    r.zero_norm = 1'b0;
    return r;
  endfunction

  // Driver: present the head of the queue; advance it on acceptance.
  // A word that waits keeps valid high until it is taken.
  always @(posedge clk) begin
    if (rst) begin
      quat.valid  <= 1'b0;
      quat.quat_w <= '0;
      quat.quat_x <= '0;
      quat.quat_y <= '0;
      quat.quat_z <= '0;
    end else begin
      if (quat.valid && quat.ready) begin
        expected_dcms.push_back(rotation_of(pending_quats.pop_front()));
      end
      if (pending_quats.size() > 0 &&
          ((quat.valid && !quat.ready) ||
           (!hold_sender && $urandom_range(99) >= send_idle_pct))) begin
        quat.valid  <= 1'b1;
        quat.quat_w <= pending_quats[0].w;
        quat.quat_x <= pending_quats[0].x;
        quat.quat_y <= pending_quats[0].y;
        quat.quat_z <= pending_quats[0].z;
      end else begin
        quat.valid <= 1'b0;
      end
    end
  end

  // Monitor: check each taken word against the oldest expectation.
  always @(posedge clk) begin
    dcm_t exp_word;
    comp_t got[qdcm_pkg::NUM_ENTRIES];
    if (rst) begin
      dcm.ready <= 1'b0;
    end else begin
      if (dcm.valid && dcm.ready) begin
        got = '{dcm.m11, dcm.m12, dcm.m13, dcm.m21, dcm.m22, dcm.m23,
                dcm.m31, dcm.m32, dcm.m33};
        if (expected_dcms.size() == 0) begin
          $display("%0t: unexpected word, got m11=%0d zero_norm=%0b",
                   $time, dcm.m11, dcm.zero_norm);
          error_count++;
        end else begin
          exp_word = expected_dcms.pop_front();
          words_checked++;
          if (exp_word.zero_norm) zero_words++;
          foreach (got[i]) begin
            if (got[i] !== exp_word.m[i]) begin
              $display("%0t: entry %0d expected %0d actual %0d",
                       $time, i, exp_word.m[i], got[i]);
              error_count++;
            end
          end
          if (dcm.zero_norm !== exp_word.zero_norm) begin
            $display("%0t: zero_norm expected %0b actual %0b",
                     $time, exp_word.zero_norm, dcm.zero_norm);
            error_count++;
          end
        end
      end
      dcm.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic comp_t random_comp();
    case ($urandom_range(5))
      0: return comp_t'(16'sh8000);
      1: return comp_t'(16'sh7fff);
      2: return comp_t'($urandom_range(7)) - comp_t'(3);
      default: return comp_t'($urandom);
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_quats.size() > 0 || quat.valid || expected_dcms.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    quat_t q;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 10; recv_idle_pct = 45;

    // Directed: zero, axes, extremes, tiny norms, mixed signs.
    pending_quats.push_back('{0, 0, 0, 0});
    pending_quats.push_back('{16384, 0, 0, 0});
    pending_quats.push_back('{0, 16384, 0, 0});
    pending_quats.push_back('{0, 0, 16384, 0});
    pending_quats.push_back('{0, 0, 0, 16384});
    pending_quats.push_back('{-32768, -32768, -32768, -32768});
    pending_quats.push_back('{32767, 32767, 32767, 32767});
    pending_quats.push_back('{32767, -32768, 32767, -32768});
    pending_quats.push_back('{-32768, 0, 0, 0});
    pending_quats.push_back('{1, 0, 0, 0});
    pending_quats.push_back('{0, 0, 0, -1});
    pending_quats.push_back('{1, 1, 1, 1});
    pending_quats.push_back('{1, -1, 1, -1});
    pending_quats.push_back('{11585, 11585, 0, 0});
    pending_quats.push_back('{8192, 8192, 8192, 8192});
    pending_quats.push_back('{-5, 3, 0, 7});
    pending_quats.push_back('{0, 0, 0, 0});
    wait_drained();

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 3) begin
        wait_drained();
        send_idle_pct = 45; recv_idle_pct = 10;
      end
      if (i == 2 * N_RANDOM / 3) begin
        wait_drained();
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      // Hold the sender once until the pipeline is empty.
      if (i == N_RANDOM / 2) begin
        hold_sender = 1'b1;
        while (quat.valid || expected_dcms.size() > 0) @(posedge clk);
        hold_sender = 1'b0;
      end
      if ($urandom_range(49) == 0) q = '0;
      else q = '{random_comp(), random_comp(), random_comp(), random_comp()};
      pending_quats.push_back(q);
      while (pending_quats.size() > 4) @(posedge clk);
    end
    wait_drained();
    repeat (LATENCY * 2) @(posedge clk);

    $display("Checked %0d matrix words, %0d of them from zero quaternions,",
             words_checked, zero_words);
    $display("under three sender/receiver stall mixes.");
    if (error_count == 0 && expected_dcms.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// ===== quaternion_to_dcm.f =====
+incdir+hdl
hdl/qdcm_pkg.sv
hdl/qdcm_ifs.sv
hdl/qdcm_divider.sv
hdl/quaternion_to_dcm.sv
tb/sv/quaternion_to_dcm_tb.sv
